>>> rtl/qec_pkg.sv
// Shared types, constants and helpers for the quadrature encoder counter.
// No dependencies; used by every file in rtl/.
`timescale 1ns / 1ps

package qec_pkg;

   localparam int COUNT_WIDTH  = 8;
   localparam int DETENT_WIDTH = 8;
   localparam int SAT_WIDTH    = (COUNT_WIDTH > DETENT_WIDTH) ? COUNT_WIDTH : DETENT_WIDTH;

   localparam logic [1:0] STEPS_SHIFT_RESET = 2'd1;
   localparam logic [7:0] DEBOUNCE_RESET    = 8'd5;
   localparam logic [1:0] STEPS_SHIFT_MAX   = 2'd2;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_READ    = 2'd1,
      KIND_CAPTURE = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_STEPS_SHIFT = 1'b0,
      CSR_DEBOUNCE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] steps_shift;
      logic [7:0] debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic                           pressed_now;
      logic signed [DETENT_WIDTH-1:0] detent_count;
   } result_type;

   function automatic logic [1:0] gray_position(input logic a, input logic b);
      gray_position = {a, a ^ b};
   endfunction

endpackage

>>> rtl/qec_core.sv
// Counter state and per-word update: position, step total, debounce timer.
// Depends on qec_pkg.
`timescale 1ns / 1ps

module qec_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          kind,
   input  logic                phase_a,
   input  logic                phase_b,
   input  logic                switch_level,
   input  qec_pkg::cfg_type    cfg,
   output qec_pkg::result_type result
);

   localparam int W  = qec_pkg::COUNT_WIDTH;
   localparam int SW = qec_pkg::SAT_WIDTH;
   localparam int DW = qec_pkg::DETENT_WIDTH;

   localparam logic signed [W-1:0] POS_LIMIT = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] NEG_LIMIT = -POS_LIMIT;
   localparam logic signed [SW-1:0] DET_MAX  = SW'((2 ** (DW-1)) - 1);
   localparam logic signed [SW-1:0] DET_MIN  = -SW'(2 ** (DW-1));

   logic [1:0]          last_position_ff, last_position_in;
   logic signed [W-1:0] step_total_ff, step_total_in;
   logic [7:0]          tick_counter_ff, tick_counter_in;
   logic                switch_pressed_ff, switch_pressed_in;

   logic [1:0]           pos;
   logic [1:0]           diff;
   logic [7:0]           tick_next;
   logic [1:0]           shift;
   logic signed [W-1:0]  quotient;
   logic [W-1:0]         rem_mask;
   logic signed [SW-1:0] quotient_wide;
   logic signed [DW-1:0] detent;

   always_comb begin
      pos       = qec_pkg::gray_position(phase_a, phase_b);
      diff      = last_position_ff - pos;
      tick_next = tick_counter_ff + 8'd1;
      shift     = (cfg.steps_shift > qec_pkg::STEPS_SHIFT_MAX) ?
                  qec_pkg::STEPS_SHIFT_MAX : cfg.steps_shift;
      quotient  = step_total_ff >>> shift;
      rem_mask  = ~({W{1'b1}} << shift);
      quotient_wide = SW'(quotient);
      if (quotient_wide > DET_MAX) begin
         detent = DET_MAX[DW-1:0];
      end else if (quotient_wide < DET_MIN) begin
         detent = DET_MIN[DW-1:0];
      end else begin
         detent = quotient_wide[DW-1:0];
      end

      last_position_in  = last_position_ff;
      step_total_in     = step_total_ff;
      tick_counter_in   = tick_counter_ff;
      switch_pressed_in = switch_pressed_ff;
      result.detent_count = '0;

      case (kind)
         qec_pkg::KIND_TICK: begin
            tick_counter_in = tick_next;
            if (diff[0]) begin
               last_position_in = pos;
               if (diff[1]) begin
                  if (step_total_ff < POS_LIMIT) step_total_in = step_total_ff + W'(1);
               end else begin
                  if (step_total_ff > NEG_LIMIT) step_total_in = step_total_ff - W'(1);
               end
            end
            if (tick_next >= cfg.debounce_ticks) begin
               switch_pressed_in = ~switch_level;
               tick_counter_in   = '0;
            end
         end
         qec_pkg::KIND_READ: begin
            step_total_in       = step_total_ff & rem_mask;
            result.detent_count = detent;
         end
         qec_pkg::KIND_CAPTURE: begin
            last_position_in = pos;
            step_total_in    = '0;
         end
         default: begin
         end
      endcase

      result.pressed_now = switch_pressed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_position_ff  <= '0;
         step_total_ff     <= '0;
         tick_counter_ff   <= '0;
         switch_pressed_ff <= 1'b0;
      end else if (accept) begin
         last_position_ff  <= last_position_in;
         step_total_ff     <= step_total_in;
         tick_counter_ff   <= tick_counter_in;
         switch_pressed_ff <= switch_pressed_in;
      end
   end

endmodule

>>> rtl/quadrature_encoder_counter.sv
// Top level: configuration registers, request handshake and result register.
// Depends on qec_pkg and qec_core.
//
//   channel   direction  handshake                payload
//   req       in         req_tvalid/req_tready    tuser kind, tdata phases and switch
//   rsp       out        rsp_tvalid/rsp_tready    tdata detent count and pressed flag
//   csr       in         csr_we                   csr_addr index, csr_wdata value
//
// One word per cycle unless rsp stalls; the response follows in the next cycle.
// The result register is the only stage: req_tready is low only while a
// response is held and rsp_tready is low.
// Synchronous reset clears the counter state and loads the register defaults.
`timescale 1ns / 1ps

module quadrature_encoder_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic [7:0]  req_tdata,   // [0] phase_a, [1] phase_b, [2] switch_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] detent_count, [8] pressed_now
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   qec_pkg::cfg_type    cfg_ff;
   qec_pkg::result_type result, rsp_data_ff;
   logic                rsp_valid_ff;
   logic                accept;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_shift    <= qec_pkg::STEPS_SHIFT_RESET;
         cfg_ff.debounce_ticks <= qec_pkg::DEBOUNCE_RESET;
      end else if (csr_we) begin
         unique case (qec_pkg::csr_index_type'(csr_addr))
            qec_pkg::CSR_STEPS_SHIFT: cfg_ff.steps_shift    <= csr_wdata[1:0];
            qec_pkg::CSR_DEBOUNCE:    cfg_ff.debounce_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   qec_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_tuser),
      .phase_a      (req_tdata[0]),
      .phase_b      (req_tdata[1]),
      .switch_level (req_tdata[2]),
      .cfg          (cfg_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.pressed_now, rsp_data_ff.detent_count};

endmodule

>>> rtl/qec_checker.sv
// Port-level checks for quadrature_encoder_counter, attached by bind.
// Depends on qec_pkg.
`timescale 1ns / 1ps

module qec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid & req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted word produced no response");

   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser != qec_pkg::KIND_READ |=> rsp_tdata[7:0] == 8'd0)
      else $error("non-read word returned a detent count");

endmodule

bind quadrature_encoder_counter qec_checker u_qec_checker (.*);
